// ===== hdl/bsm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsm_pkg: shared definitions for the Booth signed multiplier
// Field widths, the default operand width and the radix-2 Booth pair codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

  // External field widths (fixed by the interface)
  localparam int OPERAND_W = 32;
  localparam int PRODUCT_W = 64;

  // Default internal operand width, 2 .. OPERAND_W
  localparam int WIDTH_DEF = 32;

  typedef logic signed [OPERAND_W-1:0] operand_t;
  typedef logic signed [PRODUCT_W-1:0] product_t;

  // Booth pair {q[0], q[-1]} codes; the other two codes mean no action
  typedef logic [1:0] booth_pair_t;
  localparam booth_pair_t BOOTH_SUB = 2'b10;
  localparam booth_pair_t BOOTH_ADD = 2'b01;

endpackage : bsm_pkg

`default_nettype wire

// ===== hdl/bsm_cell.sv =====
// ----------------------------------------------------------------------------
// bsm_cell: one Booth round
// Applies add/subtract/hold to the accumulator from the Booth pair, shifts
// {A, Q, Q-1} right arithmetically and registers the result for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_cell #(
  parameter int WIDTH = bsm_pkg::WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  // from the previous cell
  input  wire logic             valid_in,
  input  wire logic [WIDTH-1:0] a_in,
  input  wire logic [WIDTH-1:0] q_in,
  input  wire logic             qm1_in,
  input  wire logic [WIDTH-1:0] m_in,
  // to the next cell
  output logic                  valid,
  output logic [WIDTH-1:0]      a,
  output logic [WIDTH-1:0]      q,
  output logic                  qm1,
  output logic [WIDTH-1:0]      m
);

  bsm_pkg::booth_pair_t pair;
  logic [WIDTH-1:0]     sum;
  logic [WIDTH-1:0]     a_next;
  logic [WIDTH-1:0]     q_next;

  // Booth action selected by the low multiplier bit and the extra bit
  assign pair = {q_in[0], qm1_in};

  always_comb begin
    case (pair)
      bsm_pkg::BOOTH_SUB: sum = a_in - m_in;
      bsm_pkg::BOOTH_ADD: sum = a_in + m_in;
      default:            sum = a_in;
    endcase
  end

  // Arithmetic right shift of {A, Q} as one word
  assign a_next = {sum[WIDTH-1], sum[WIDTH-1:1]};
  assign q_next = {sum[0], q_in[WIDTH-1:1]};

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= valid_in;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (advance) begin
      a   <= a_next;
      q   <= q_next;
      qm1 <= q_in[0];
      m   <= m_in;
    end
  end

endmodule : bsm_cell

`default_nettype wire

// ===== hdl/booth_signed_multiplier.sv =====
// ----------------------------------------------------------------------------
// booth_signed_multiplier: radix-2 Booth signed multiplier
// A row of WIDTH Booth cells, one round per cell; the last cell's register
// holds the finished product for the output channel.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_ready, multiplicand,    | input
//          | multiplier                           |
//  out     | out_valid, out_ready, product        | output
//
//  Each cell in the row is one register stage: the first cell loads at the
//  accepting edge, and out_valid rises when the last cell registers the result.
//  A new transaction is taken every cycle while the output is not stalled. The
//  whole row moves together; it holds when the result in the last cell is not
//  taken, and in_ready follows !out_valid || out_ready.
//  Synchronous reset clears the valid bit of every cell.
// ----------------------------------------------------------------------------
`default_nettype none

module booth_signed_multiplier #(
  parameter int WIDTH = bsm_pkg::WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bsm_pkg::operand_t multiplicand,
  input  wire bsm_pkg::operand_t multiplier,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bsm_pkg::product_t      product
);

  // Per-link signals; link 0 is the input, link WIDTH is the last cell
  logic                 link_valid [WIDTH+1];
  logic [WIDTH-1:0]     link_a     [WIDTH+1];
  logic [WIDTH-1:0]     link_q     [WIDTH+1];
  logic                 link_qm1   [WIDTH+1];
  logic [WIDTH-1:0]     link_m     [WIDTH+1];
  logic                 advance;
  logic signed [2*WIDTH-1:0] prod_raw;

  // The row moves when the last cell is empty or its result is taken
  assign advance  = !link_valid[WIDTH] || out_ready;
  assign in_ready = advance;

  // Round 0 operands: A and Q-1 cleared, Q and M from the low WIDTH bits
  assign link_valid[0] = in_valid;
  assign link_a[0]     = '0;
  assign link_q[0]     = multiplier[WIDTH-1:0];
  assign link_qm1[0]   = 1'b0;
  assign link_m[0]     = multiplicand[WIDTH-1:0];

  // Row of Booth cells
  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    bsm_cell #(
      .WIDTH (WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .valid_in (link_valid[i]),
      .a_in     (link_a[i]),
      .q_in     (link_q[i]),
      .qm1_in   (link_qm1[i]),
      .m_in     (link_m[i]),
      .valid    (link_valid[i+1]),
      .a        (link_a[i+1]),
      .q        (link_q[i+1]),
      .qm1      (link_qm1[i+1]),
      .m        (link_m[i+1])
    );
  end

  // Product {A, Q}, sign-extended to the port width
  assign prod_raw  = {link_a[WIDTH], link_q[WIDTH]};
  assign product   = bsm_pkg::product_t'(prod_raw);
  assign out_valid = link_valid[WIDTH];

endmodule : booth_signed_multiplier

`default_nettype wire

// ===== hdl/bsm_checker.sv =====
// ----------------------------------------------------------------------------
// bsm_checker: port-level checks for the Booth signed multiplier
// Watches the handshake and stall behavior seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire bsm_pkg::operand_t multiplicand,
  input wire bsm_pkg::operand_t multiplier,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire bsm_pkg::product_t product
);

  // No result is offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(product))
    else $error("stalled product changed or dropped");

  // A waiting input transaction keeps its operands
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(multiplicand) && $stable(multiplier))
    else $error("waiting operands changed or dropped");

  // A stalled output stalls the input side
  a_stall_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // With nothing waiting at the output the row always takes a transaction
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("in_ready low with free output");

endmodule : bsm_checker

bind booth_signed_multiplier bsm_checker u_bsm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .multiplicand (multiplicand),
  .multiplier   (multiplier),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .product      (product)
);

`default_nettype wire

// ===== dv/tb_booth_signed_multiplier.sv =====
// ----------------------------------------------------------------------------
// tb_booth_signed_multiplier: self-checking bench for the Booth multiplier
// Drives operand pairs over the input valid/ready channel and predicts each
// product with a bit-level radix-2 Booth model. A scoreboard matches the
// products in order. The run covers directed corner operands and random
// operands under several idle/stall mixes, plus one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_booth_signed_multiplier;

  localparam int W           = bsm_pkg::WIDTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  // Scoreboard: expected products in arrival order
  class product_scoreboard;
    bsm_pkg::product_t expected_q[$];
    int unsigned       checked;
    int unsigned       failures;

    // Radix-2 Booth over W rounds on {acc, q, q_prev}
    function bsm_pkg::product_t booth_product(bsm_pkg::operand_t mcand,
                                              bsm_pkg::operand_t mplier);
      logic [W-1:0]          m;
      logic [W-1:0]          acc;
      logic [W-1:0]          q;
      logic                  q_prev;
      logic signed [2*W-1:0] full;
      int                    rnd;
      m      = mcand[W-1:0];
      q      = mplier[W-1:0];
      acc    = '0;
      q_prev = 1'b0;
      for (rnd = 0; rnd < W; rnd++) begin
        case ({q[0], q_prev})
          bsm_pkg::BOOTH_SUB: acc = acc - m;
          bsm_pkg::BOOTH_ADD: acc = acc + m;
          default: ;
        endcase
        q_prev   = q[0];
        // arithmetic shift of the whole group
        {acc, q} = {acc[W-1], acc, q[W-1:1]};
      end
      full = {acc, q};
      return bsm_pkg::product_t'(full);
    endfunction

    function void note_operands(bsm_pkg::operand_t mcand, bsm_pkg::operand_t mplier);
      expected_q.push_back(booth_product(mcand, mplier));
    endfunction

    function void check_product(bsm_pkg::product_t actual);
      bsm_pkg::product_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("ERROR: product %h arrived with nothing expected", actual);
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (actual !== want) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("ERROR: product mismatch #%0d: expected %h, got %h",
                     checked, want, actual);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  bsm_pkg::operand_t multiplicand = '0;
  bsm_pkg::operand_t multiplier = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  bsm_pkg::product_t product;

  product_scoreboard sb;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  bit                hold_off = 1'b0;
  int unsigned       pairs_sent = 0;
  int unsigned       cycle_count = 0;

  booth_signed_multiplier #(.WIDTH(W)) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .multiplicand (multiplicand),
    .multiplier   (multiplier),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .product      (product)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL booth_signed_multiplier");
      $finish;
    end
  end

  // Output side: random stalls, forced low during a hold-off
  always @(negedge clk) begin
    out_ready <= hold_off ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every completed output transaction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_product(product);
  end

  // Operand mix: extremes, small values, Booth-heavy patterns, powers of two, full random
  function automatic bsm_pkg::operand_t pick_operand();
    bsm_pkg::operand_t v;
    case ($urandom_range(7))
      0: v = {1'b1, {(bsm_pkg::OPERAND_W-1){1'b0}}};
      1: v = {1'b0, {(bsm_pkg::OPERAND_W-1){1'b1}}};
      2: v = bsm_pkg::operand_t'($urandom_range(32)) - 16;
      3: v = $urandom_range(1) ? {(bsm_pkg::OPERAND_W/2){2'b01}}
                               : {(bsm_pkg::OPERAND_W/2){2'b10}};
      4: v = bsm_pkg::operand_t'(1) << $urandom_range(bsm_pkg::OPERAND_W-1);
      5: v = -bsm_pkg::operand_t'($urandom_range(1000));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Offer one transaction; called and returns at a falling edge
  task automatic send_operands(bsm_pkg::operand_t mcand, bsm_pkg::operand_t mplier);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    multiplicand <= mcand;
    multiplier   <= mplier;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_operands(mcand, mplier);
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_operands(pick_operand(), pick_operand());
  endtask

  task automatic run_phase(int unsigned count, int unsigned idle_pct,
                           int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    send_random(count);
  endtask

  // Hold the output off long enough for the pipeline to back up
  task automatic hold_output(int unsigned cycles);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off = 1'b0;
  endtask

  bsm_pkg::operand_t max_pos = {1'b0, {(bsm_pkg::OPERAND_W-1){1'b1}}};
  bsm_pkg::operand_t max_neg = {1'b1, {(bsm_pkg::OPERAND_W-1){1'b0}}};
  bsm_pkg::operand_t alt_lo  = {(bsm_pkg::OPERAND_W/2){2'b01}};
  bsm_pkg::operand_t alt_hi  = {(bsm_pkg::OPERAND_W/2){2'b10}};

  initial begin
    bsm_pkg::operand_t dir_mcand[$];
    bsm_pkg::operand_t dir_mplier[$];
    sb = new();
    dir_mcand  = '{0, 1, -1, max_neg, max_neg, max_pos, max_neg, max_pos, max_neg, 0,
                   -1, 1, alt_lo, alt_hi, alt_lo, 7, -3, 12345, 1, max_pos, -1, alt_hi};
    dir_mplier = '{0, 1, -1, max_neg, max_pos, max_pos, -1, -1, 0, max_neg,
                   max_pos, max_neg, alt_hi, alt_lo, alt_lo, -3, 7, -67890, -1, 1, 0, alt_hi};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed corners, back to back
    foreach (dir_mcand[i]) send_operands(dir_mcand[i], dir_mplier[i]);

    // Random operands under different idle/stall mixes
    run_phase(90, 0, 0);
    run_phase(90, 84, 0);
    run_phase(90, 0, 84);
    run_phase(90, 27, 27);

    // Back-pressure: input keeps offering while output is held off
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      send_random(80);
      hold_output(HOLD_CYCLES);
    join
    in_valid <= 1'b0;

    // Drain the pipeline, then watch for stray products
    while (sb.pending() != 0) @(posedge clk);
    repeat (W + 8) @(posedge clk);

    $display("Covered %0d operand pairs, %0d products checked, %0d failures.",
             pairs_sent, sb.checked, sb.failures);
    $display("Phases: directed corners, idle/stall mixes, %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS booth_signed_multiplier");
    end else begin
      $display("FAIL booth_signed_multiplier");
    end
    $finish;
  end

endmodule
